### hw/rtl/cvgc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvgc_pkg
// Types, constants and CRC-15 helpers shared by the cell voltage group checker.
// ----------------------------------------------------------------------------
package cvgc_pkg;

    localparam int unsigned REGISTER_GROUPS = 4;
    localparam int unsigned CELLS_PER_GROUP = 3;
    localparam int unsigned CELL_SLOTS      = 12;

    localparam logic [15:0] PEC_SEED = 16'd16;
    localparam logic [15:0] PEC_POLY = 16'h4599;

    // configuration register indexes
    localparam logic [1:0] CFG_CELLS_PRESENT = 2'd0;
    localparam logic [1:0] CFG_WARN_VOLTAGE  = 2'd1;
    localparam logic [1:0] CFG_MIN_VOLTAGE   = 2'd2;
    localparam logic [1:0] CFG_MAX_VOLTAGE   = 2'd3;

    localparam logic [11:0] RST_CELLS_PRESENT = 12'd4095;
    localparam logic [15:0] RST_WARN_VOLTAGE  = 16'd32000;
    localparam logic [15:0] RST_MIN_VOLTAGE   = 16'd30000;
    localparam logic [15:0] RST_MAX_VOLTAGE   = 16'd42000;

    typedef logic [15:0] t_code;

    // one classified register group, as queued between front and back
    typedef struct packed {
        logic                       group_zero;
        logic                       pec_ok;
        logic [CELLS_PER_GROUP-1:0] present;
        t_code                      code_a;
        t_code                      code_b;
        t_code                      code_c;
    } t_entry;

    // thresholds for the voltage compares
    typedef struct packed {
        t_code warn;
        t_code vmin;
        t_code vmax;
    } t_limits;

    typedef struct packed {
        logic       cell_valid;
        logic [3:0] cell_index;
        t_code      cell_voltage;
        logic       low_warning;
        logic       under_voltage;
        logic       over_voltage;
        logic       pec_error;
        logic       last;
    } t_result;

    function automatic logic [15:0] pec_entry(input logic [7:0] a);
        logic [15:0] r;
        r = {1'b0, a, 7'b0};
        for (int b = 0; b < 8; b++) begin
            if (r[14]) begin
                r = {r[14:0], 1'b0} ^ PEC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] pec_byte(input logic [15:0] rem, input logic [7:0] data);
        logic [7:0] addr;
        addr = rem[14:7] ^ data;
        return {rem[7:0], 8'h00} ^ pec_entry(addr);
    endfunction

    // one cell code, low byte first
    function automatic logic [15:0] pec_code(input logic [15:0] rem, input t_code code);
        return pec_byte(pec_byte(rem, code[7:0]), code[15:8]);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cvgc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvgc_front
// Accepts register groups, runs the CRC-15 over three pipeline steps (one
// cell code each) and classifies slots as present.
// ----------------------------------------------------------------------------
module cvgc_front
    import cvgc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_group_number,
    input  wire t_code       i_cell_code_a,
    input  wire t_code       i_cell_code_b,
    input  wire t_code       i_cell_code_c,
    input  wire t_code       i_pec_received,
    input  wire logic [11:0] i_cells_present,
    input  wire logic        i_queue_full,
    output logic             o_push,
    output t_entry           o_entry
);

    typedef struct packed {
        t_entry      e;
        t_code       pec;
        logic [15:0] rem;
    } t_work;

    logic  r_v1, r_v2;
    t_work r_s1, r_s2;
    t_work n_s1, n_s2;
    logic  accept, adv2;
    logic [CELLS_PER_GROUP-1:0] present;
    logic [15:0] rem_final;

    always_comb begin
        logic [3:0] idx;
        for (int c = 0; c < CELLS_PER_GROUP; c++) begin
            idx = 4'(i_group_number * CELLS_PER_GROUP + c);
            present[c] = (32'(i_group_number) < REGISTER_GROUPS) &&
                         (32'(idx) < CELL_SLOTS) && i_cells_present[idx];
        end
    end

    assign o_push  = r_v2 && !i_queue_full;
    assign adv2    = r_v1 && (!r_v2 || o_push);
    assign o_stall = r_v1 && r_v2 && i_queue_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_s1.e.group_zero = (i_group_number == 2'd0);
        n_s1.e.pec_ok     = 1'b0;
        n_s1.e.present    = present;
        n_s1.e.code_a     = i_cell_code_a;
        n_s1.e.code_b     = i_cell_code_b;
        n_s1.e.code_c     = i_cell_code_c;
        n_s1.pec          = i_pec_received;
        n_s1.rem          = pec_code(PEC_SEED, i_cell_code_a);

        n_s2     = r_s1;
        n_s2.rem = pec_code(r_s1.rem, r_s1.e.code_b);

        rem_final      = pec_code(r_s2.rem, r_s2.e.code_c);
        o_entry        = r_s2.e;
        o_entry.pec_ok = ({rem_final[14:0], 1'b0} == r_s2.pec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv2) begin
                r_v1 <= 1'b0;
            end
            if (adv2) begin
                r_v2 <= 1'b1;
            end else if (o_push) begin
                r_v2 <= 1'b0;
            end
        end
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cvgc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvgc_queue
// Short register queue of classified groups between front and back.
// ----------------------------------------------------------------------------
module cvgc_queue
    import cvgc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_nonempty,
    output t_entry      o_head
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cvgc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvgc_back
// Walks the present slots of the queue head, one result per cycle when not
// stalled, keeps the running cell index and drives the output register.
// ----------------------------------------------------------------------------
module cvgc_back
    import cvgc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_head_valid,
    input  wire t_entry  i_head,
    input  wire t_limits i_limits,
    input  wire logic    i_stall,
    output logic         o_pop,
    output logic         o_valid,
    output t_result      o_result
);

    logic [CELLS_PER_GROUP-1:0] r_done, n_done;
    logic                       r_started, n_started;
    logic [3:0]                 r_count, n_count;
    logic                       r_ovalid, n_ovalid;
    t_result                    r_res, n_res;

    logic [CELLS_PER_GROUP-1:0] rem, sel;
    logic [3:0]                 base;
    logic                       out_ready;
    t_code                      volt;

    always_comb begin
        rem       = i_head.present & ~r_done;
        sel       = rem & CELLS_PER_GROUP'(~rem + 1'b1);
        base      = (!r_started && i_head.group_zero) ? 4'd0 : r_count;
        out_ready = !r_ovalid || !i_stall;

        if (sel[0]) begin
            volt = i_head.code_a;
        end else if (sel[1]) begin
            volt = i_head.code_b;
        end else begin
            volt = i_head.code_c;
        end

        n_done    = r_done;
        n_started = r_started;
        n_count   = r_count;
        n_ovalid  = r_ovalid && i_stall;
        n_res     = r_res;
        o_pop     = 1'b0;

        if (i_head_valid && out_ready) begin
            if (!i_head.pec_ok) begin
                n_ovalid             = 1'b1;
                n_res.cell_valid     = 1'b0;
                n_res.cell_index     = base;
                n_res.cell_voltage   = '0;
                n_res.low_warning    = 1'b0;
                n_res.under_voltage  = 1'b0;
                n_res.over_voltage   = 1'b0;
                n_res.pec_error      = 1'b1;
                n_res.last           = 1'b1;
                n_count              = base;
                o_pop                = 1'b1;
            end else if (rem == '0) begin
                // no wired cell in this group: drop it, restart the index on group zero
                n_count = base;
                o_pop   = 1'b1;
            end else begin
                n_ovalid             = 1'b1;
                n_res.cell_valid     = 1'b1;
                n_res.cell_index     = base;
                n_res.cell_voltage   = volt;
                n_res.low_warning    = (volt < i_limits.warn);
                n_res.under_voltage  = (volt < i_limits.vmin);
                n_res.over_voltage   = (volt > i_limits.vmax);
                n_res.pec_error      = 1'b0;
                n_res.last           = ((rem & ~sel) == '0);
                n_count              = 4'(base + 1'b1);
                n_done               = r_done | sel;
                n_started            = 1'b1;
                o_pop                = n_res.last;
            end
            if (o_pop) begin
                n_done    = '0;
                n_started = 1'b0;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_started <= 1'b0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_done    <= n_done;
            r_started <= n_started;
            r_count   <= n_count;
            r_ovalid  <= n_ovalid;
        end
        r_res <= n_res;
    end

endmodule

`default_nettype wire

### hw/rtl/cell_voltage_group_checker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cell_voltage_group_checker_core
// Checks the CRC-15 PEC of a received cell-voltage register group and reports
// each wired cell with its running index and threshold flags.
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// input     in         i_valid / o_stall              group number, 3 codes, PEC
// result    out        o_valid / i_stall              cell fields, pec_error, last
// config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A group passes three front pipeline steps (one cell code of CRC each) and
// the queue, then the back emits one result per cycle while the result side
// is not stalled, one per wired cell or a single PEC error result; a new
// group can be taken every cycle while the queue has room. Reset clears the
// pipeline, queue and running index and loads the reset configuration.
// A stall on the result side holds the output register and backs up the queue.
// ----------------------------------------------------------------------------
module cell_voltage_group_checker_core
    import cvgc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_group_number,
    input  wire logic [15:0] i_cell_code_a,
    input  wire logic [15:0] i_cell_code_b,
    input  wire logic [15:0] i_cell_code_c,
    input  wire logic [15:0] i_pec_received,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_cell_valid,
    output logic [3:0]       o_cell_index,
    output logic [15:0]      o_cell_voltage,
    output logic             o_low_warning,
    output logic             o_under_voltage,
    output logic             o_over_voltage,
    output logic             o_pec_error,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [11:0] r_cells_present;
    t_limits     r_limits;

    logic    push, pop, full, nonempty;
    t_entry  entry, head;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_present <= RST_CELLS_PRESENT;
            r_limits.warn   <= RST_WARN_VOLTAGE;
            r_limits.vmin   <= RST_MIN_VOLTAGE;
            r_limits.vmax   <= RST_MAX_VOLTAGE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CELLS_PRESENT: r_cells_present <= i_cfg_data[11:0];
                CFG_WARN_VOLTAGE:  r_limits.warn   <= i_cfg_data;
                CFG_MIN_VOLTAGE:   r_limits.vmin   <= i_cfg_data;
                CFG_MAX_VOLTAGE:   r_limits.vmax   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cvgc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_group_number  (i_group_number),
        .i_cell_code_a   (i_cell_code_a),
        .i_cell_code_b   (i_cell_code_b),
        .i_cell_code_c   (i_cell_code_c),
        .i_pec_received  (i_pec_received),
        .i_cells_present (r_cells_present),
        .i_queue_full    (full),
        .o_push          (push),
        .o_entry         (entry)
    );

    cvgc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (entry),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    cvgc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (nonempty),
        .i_head       (head),
        .i_limits     (r_limits),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_result     (result)
    );

    assign o_cell_valid    = result.cell_valid;
    assign o_cell_index    = result.cell_index;
    assign o_cell_voltage  = result.cell_voltage;
    assign o_low_warning   = result.low_warning;
    assign o_under_voltage = result.under_voltage;
    assign o_over_voltage  = result.over_voltage;
    assign o_pec_error     = result.pec_error;
    assign o_last          = result.last;

endmodule

`default_nettype wire

### hw/rtl/cvgc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvgc_checker
// Port-level checks of the cell voltage group checker, bound to the top level.
// ----------------------------------------------------------------------------
module cvgc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_cell_valid,
    input wire logic [3:0]  o_cell_index,
    input wire logic [15:0] o_cell_voltage,
    input wire logic        o_low_warning,
    input wire logic        o_under_voltage,
    input wire logic        o_over_voltage,
    input wire logic        o_pec_error,
    input wire logic        o_last
);

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_voltage) && $stable(o_cell_index)
            && $stable(o_last) && $stable(o_pec_error))
        else $error("stalled result changed");

    // a PEC error is a single, empty, final transaction
    a_pec_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pec_error |-> o_last && !o_cell_valid && (o_cell_voltage == 16'd0)
            && !o_low_warning && !o_under_voltage && !o_over_voltage)
        else $error("malformed PEC error result");

    // every result is either a cell or a PEC error
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cell_valid != o_pec_error))
        else $error("result is neither cell nor error");

    // cells of one group carry consecutive indexes
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_cell_valid && !o_last) ##1 o_valid
            |-> o_cell_valid && (o_cell_index == 4'($past(o_cell_index) + 4'd1)))
        else $error("running cell index skipped");

endmodule

bind cell_voltage_group_checker_core cvgc_checker u_cvgc_checker (.*);

`default_nettype wire

### sim/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives received cell-voltage register groups into the checker, predicts the
// CRC-15 verdict and the per-cell reports, and compares every result in order.
// Covers reset thresholds, cell masks, threshold extremes, running index wrap,
// random traffic under three idling patterns and a long result-side hold-off.
// ----------------------------------------------------------------------------
module testbench
    import cvgc_pkg::*;
();

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE_TICKS = 16;
    localparam logic [15:0] CRC_SEED     = 16'd16;
    localparam logic [15:0] CRC_POLY     = 16'h4599;

    typedef struct {
        logic [1:0]  group;
        logic [15:0] code_a;
        logic [15:0] code_b;
        logic [15:0] code_c;
        logic [15:0] pec;
    } t_group_item;

    typedef struct {
        logic        cell_valid;
        logic [3:0]  cell_index;
        logic [15:0] cell_voltage;
        logic        low_warning;
        logic        under_voltage;
        logic        over_voltage;
        logic        pec_error;
        logic        last;
    } t_cell_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_group_number = '0;
    logic [15:0] i_cell_code_a = '0;
    logic [15:0] i_cell_code_b = '0;
    logic [15:0] i_cell_code_c = '0;
    logic [15:0] i_pec_received = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_cell_valid;
    logic [3:0]  o_cell_index;
    logic [15:0] o_cell_voltage;
    logic        o_low_warning;
    logic        o_under_voltage;
    logic        o_over_voltage;
    logic        o_pec_error;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // predictor copy of the block's registers and state
    logic [11:0] wired_mask = RST_CELLS_PRESENT;
    logic [15:0] warn_level = RST_WARN_VOLTAGE;
    logic [15:0] min_level = RST_MIN_VOLTAGE;
    logic [15:0] max_level = RST_MAX_VOLTAGE;
    logic [3:0]  running_index = '0;

    t_cell_report expected_reports[$];
    t_cell_report want;
    int failures = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;

    cell_voltage_group_checker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_group_number (i_group_number),
        .i_cell_code_a  (i_cell_code_a),
        .i_cell_code_b  (i_cell_code_b),
        .i_cell_code_c  (i_cell_code_c),
        .i_pec_received (i_pec_received),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cell_valid   (o_cell_valid),
        .o_cell_index   (o_cell_index),
        .o_cell_voltage (o_cell_voltage),
        .o_low_warning  (o_low_warning),
        .o_under_voltage(o_under_voltage),
        .o_over_voltage (o_over_voltage),
        .o_pec_error    (o_pec_error),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result-side stall: a requested hold-off wins over random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                $error("result with nothing expected: cell_index %0d, pec_error %0b",
                       o_cell_index, o_pec_error);
                failures++;
            end else begin
                want = expected_reports.pop_front();
                check_field("cell_valid", 16'(want.cell_valid), 16'(o_cell_valid));
                check_field("cell_index", 16'(want.cell_index), 16'(o_cell_index));
                check_field("cell_voltage", want.cell_voltage, o_cell_voltage);
                check_field("low_warning", 16'(want.low_warning), 16'(o_low_warning));
                check_field("under_voltage", 16'(want.under_voltage), 16'(o_under_voltage));
                check_field("over_voltage", 16'(want.over_voltage), 16'(o_over_voltage));
                check_field("pec_error", 16'(want.pec_error), 16'(o_pec_error));
                check_field("last", 16'(want.last), 16'(o_last));
            end
        end
    end

    // CRC-15 over the six data bytes, each code low byte first
    function automatic logic [15:0] group_crc15(input logic [15:0] a, input logic [15:0] b,
                                                input logic [15:0] c);
        logic [7:0]  msg [6];
        logic [15:0] rem;
        logic [15:0] term;
        msg = '{a[7:0], a[15:8], b[7:0], b[15:8], c[7:0], c[15:8]};
        rem = CRC_SEED;
        for (int i = 0; i < 6; i++) begin
            term = {1'b0, rem[14:7] ^ msg[i], 7'd0};
            for (int k = 0; k < 8; k++) begin
                term = term[14] ? ({term[14:0], 1'b0} ^ CRC_POLY) : {term[14:0], 1'b0};
            end
            rem = {rem[7:0], 8'h00} ^ term;
        end
        return {rem[14:0], 1'b0};
    endfunction

    function automatic void predict_group_reports(input t_group_item it);
        logic [15:0]  codes [3];
        logic [2:0]   wired;
        t_cell_report rep;
        codes = '{it.code_a, it.code_b, it.code_c};
        wired = 3'(wired_mask >> (it.group * CELLS_PER_GROUP));
        if (it.group == 2'd0) begin
            running_index = '0;
        end
        if (group_crc15(it.code_a, it.code_b, it.code_c) != it.pec) begin
            rep = '{cell_valid: 1'b0, cell_index: running_index, cell_voltage: 16'd0,
                    low_warning: 1'b0, under_voltage: 1'b0, over_voltage: 1'b0,
                    pec_error: 1'b1, last: 1'b1};
            expected_reports.push_back(rep);
        end else begin
            for (int c = 0; c < CELLS_PER_GROUP; c++) begin
                if (wired[c]) begin
                    rep.cell_valid    = 1'b1;
                    rep.cell_index    = running_index;
                    rep.cell_voltage  = codes[c];
                    rep.low_warning   = codes[c] < warn_level;
                    rep.under_voltage = codes[c] < min_level;
                    rep.over_voltage  = codes[c] > max_level;
                    rep.pec_error     = 1'b0;
                    rep.last          = (wired >> (c + 1)) == 3'd0;
                    expected_reports.push_back(rep);
                    running_index = running_index + 4'd1;
                end
            end
        end
    endfunction

    function automatic t_group_item build_group(input logic [1:0] g, input logic [15:0] a,
                                                input logic [15:0] b, input logic [15:0] c,
                                                input bit corrupt);
        t_group_item it;
        it.group  = g;
        it.code_a = a;
        it.code_b = b;
        it.code_c = c;
        it.pec    = group_crc15(a, b, c);
        if (corrupt) begin
            it.pec = it.pec ^ 16'($urandom_range(1, 65535));
        end
        return it;
    endfunction

    // favor codes on and around the thresholds
    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hffff;
            2: return warn_level + 16'($urandom_range(0, 2)) - 16'd1;
            3: return min_level + 16'($urandom_range(0, 2)) - 16'd1;
            4: return max_level + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_group_item random_group(input logic [1:0] g, input int bad_pct);
        return build_group(g, pick_code(), pick_code(), pick_code(),
                           $urandom_range(0, 99) < bad_pct);
    endfunction

    task automatic send_group(input t_group_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_group_number <= it.group;
        i_cell_code_a  <= it.code_a;
        i_cell_code_b  <= it.code_b;
        i_cell_code_c  <= it.code_c;
        i_pec_received <= it.pec;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_group_reports(it);
    endtask

    // drop valid, wait for every expected result, then let empty groups clear
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_CELLS_PRESENT: wired_mask = data[11:0];
            CFG_WARN_VOLTAGE:  warn_level = data;
            CFG_MIN_VOLTAGE:   min_level = data;
            CFG_MAX_VOLTAGE:   max_level = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_thresholds();
        send_group(build_group(2'd0, 16'd0, 16'hffff, 16'd30000, 1'b0));
        send_group(build_group(2'd1, 16'd29999, 16'd31999, 16'd32000, 1'b0));
        send_group(build_group(2'd2, 16'd42000, 16'd42001, 16'd32001, 1'b0));
        send_group(build_group(2'd3, 16'hffff, 16'd0, 16'hffff, 1'b1));
        // group zero restarts the index even when its PEC is bad
        send_group(build_group(2'd0, 16'd12345, 16'd23456, 16'd34567, 1'b1));
        send_group(build_group(2'd1, 16'd40000, 16'd41000, 16'd42000, 1'b0));
        wait_quiet();
    endtask

    task automatic test_cell_mask();
        write_reg(CFG_CELLS_PRESENT, 16'h0000);
        send_group(build_group(2'd0, 16'd31000, 16'd33000, 16'd35000, 1'b0));
        send_group(build_group(2'd1, 16'd31000, 16'd33000, 16'd35000, 1'b0));
        send_group(build_group(2'd2, 16'd31000, 16'd33000, 16'd35000, 1'b1));
        wait_quiet();
        // upper data bits fall outside the twelve cell slots
        write_reg(CFG_CELLS_PRESENT, 16'hf5a4);
        send_group(build_group(2'd0, 16'd100, 16'd200, 16'd300, 1'b0));
        send_group(build_group(2'd1, 16'd400, 16'd500, 16'd600, 1'b0));
        send_group(build_group(2'd2, 16'd700, 16'd800, 16'd900, 1'b0));
        send_group(build_group(2'd3, 16'd1000, 16'd1100, 16'd1200, 1'b0));
        wait_quiet();
    endtask

    task automatic test_threshold_extremes();
        write_reg(CFG_CELLS_PRESENT, 16'hffff);
        write_reg(CFG_WARN_VOLTAGE, 16'h0000);
        write_reg(CFG_MIN_VOLTAGE, 16'h0000);
        write_reg(CFG_MAX_VOLTAGE, 16'hffff);
        send_group(build_group(2'd0, 16'd0, 16'hffff, 16'd1, 1'b0));
        wait_quiet();
        write_reg(CFG_WARN_VOLTAGE, 16'hffff);
        write_reg(CFG_MIN_VOLTAGE, 16'hffff);
        write_reg(CFG_MAX_VOLTAGE, 16'h0000);
        send_group(build_group(2'd1, 16'd0, 16'hffff, 16'd1, 1'b0));
        send_group(build_group(2'd2, 16'hffff, 16'hfffe, 16'd0, 1'b0));
        wait_quiet();
    endtask

    task automatic test_index_wrap();
        logic [1:0] order [8];
        order = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
        write_reg(CFG_WARN_VOLTAGE, RST_WARN_VOLTAGE);
        write_reg(CFG_MIN_VOLTAGE, RST_MIN_VOLTAGE);
        write_reg(CFG_MAX_VOLTAGE, RST_MAX_VOLTAGE);
        // 21 wired cells before the next group zero: the index passes 15
        foreach (order[i]) begin
            send_group(random_group(order[i], 0));
        end
        wait_quiet();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        int sent;
        int run_len;
        send_idle_pct  = src_pct;
        sink_stall_pct = sink_pct;
        write_reg(CFG_CELLS_PRESENT, 16'($urandom_range(0, 65535)));
        write_reg(CFG_WARN_VOLTAGE, 16'($urandom_range(0, 65535)));
        write_reg(CFG_MIN_VOLTAGE, 16'($urandom_range(0, 65535)));
        write_reg(CFG_MAX_VOLTAGE, 16'($urandom_range(0, 65535)));
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                // a read sweep: group zero, then a run of later groups
                send_group(random_group(2'd0, 10));
                sent++;
                run_len = $urandom_range(2, 7);
                for (int i = 0; i < run_len; i++) begin
                    send_group(random_group(2'($urandom_range(1, 3)), 10));
                    sent++;
                end
            end else begin
                send_group(random_group(2'($urandom_range(0, 3)), 50));
                sent++;
            end
        end
        wait_quiet();
    endtask

    task automatic test_result_holdoff();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        write_reg(CFG_CELLS_PRESENT, 16'h0fff);
        hold_left = 120;
        send_group(random_group(2'd0, 0));
        for (int i = 0; i < 23; i++) begin
            send_group(random_group(2'($urandom_range(0, 3)), 15));
        end
        wait_quiet();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_thresholds();
        test_cell_mask();
        test_threshold_extremes();
        test_index_wrap();
        test_random_traffic(21, 74, 110);
        test_random_traffic(74, 21, 110);
        test_random_traffic(0, 0, 110);
        test_result_holdoff();
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
